// File: hw/rtl/sha_pkg.sv
// SHA-256 hasher package: command types, round constants and round functions.
// Used by the front, the command queue and the back end; depends on nothing.
`timescale 1ns / 1ps
package sha_pkg;

  localparam logic [1:0] REQ_ABSORB     = 2'd0;
  localparam logic [1:0] REQ_ABSORB_FIN = 2'd1;
  localparam logic [1:0] REQ_FINALIZE   = 2'd2;

  localparam logic [1:0] CMD_ABSORB     = 2'd0;
  localparam logic [1:0] CMD_ABSORB_FIN = 2'd1;
  localparam logic [1:0] CMD_FINALIZE   = 2'd2;
  localparam logic [1:0] CMD_REFUSE     = 2'd3;

  localparam logic [60:0] BYTE_LIMIT = {61{1'b1}};
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [6:0]  LEN_FILL   = 7'd56;
  localparam logic [6:0]  BLOCK_FILL = 7'd64;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    round_k = k[i];
  endfunction

endpackage

// File: hw/rtl/sha_front.sv
// Front end of the SHA-256 hasher: accepts requests and classifies them.
// Tracks the message length to refuse bytes past the limit; uses sha_pkg.
`timescale 1ns / 1ps
module sha_front import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       queue_full
);

  logic [60:0] length;
  logic        at_limit;
  logic        take;

  assign in_ready = !queue_full;
  assign take     = in_valid && !queue_full;
  assign at_limit = (length == BYTE_LIMIT);

  always_comb begin
    push          = 1'b0;
    push_cmd.kind = CMD_FINALIZE;
    push_cmd.data = in_data;
    case (in_kind)
      REQ_ABSORB: begin
        push          = take;
        push_cmd.kind = at_limit ? CMD_REFUSE : CMD_ABSORB;
      end
      REQ_ABSORB_FIN: begin
        push          = take;
        push_cmd.kind = at_limit ? CMD_REFUSE : CMD_ABSORB_FIN;
      end
      REQ_FINALIZE: begin
        push          = take;
        push_cmd.kind = CMD_FINALIZE;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (push) begin
      if (push_cmd.kind == CMD_ABSORB) begin
        length <= length + 61'd1;
      end else if (push_cmd.kind == CMD_ABSORB_FIN || push_cmd.kind == CMD_FINALIZE) begin
        length <= '0;
      end
    end
  end

endmodule

// File: hw/rtl/sha_fifo.sv
// Short command queue between the front and back ends of the hasher.
// Register-based FIFO of sha_pkg::cmd_t entries.
`timescale 1ns / 1ps
module sha_fifo import sha_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/sha_back.sv
// Back end of the hasher: block assembly, padding, 64-round compression, output.
// Pops commands from sha_fifo; uses sha_pkg for constants and round functions.
`timescale 1ns / 1ps
module sha_back import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [2:0]  out_index,
  output logic [31:0] out_word,
  output logic        out_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_COMP = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]   state;
  logic [2:0]   ret_state;
  logic [511:0] blk;
  logic [6:0]   fill;
  logic [60:0]  length;
  logic [31:0]  hash [8];
  logic [31:0]  v [8];
  logic [5:0]   rnd;
  logic [2:0]   idx;
  logic         pad_first;
  logic         slot_free;
  logic         out_load;

  logic         do_push;
  logic [7:0]   push_byte;
  logic [2:0]   after_push;
  logic [63:0]  bit_len;
  logic [31:0]  win0, win1, win9, win14, w_new;
  logic [31:0]  t1, t2, ch, mj;

  assign slot_free = !out_valid || out_ready;
  assign pop       = (state == ST_IDLE) && cmd_valid &&
                     (cmd.kind != CMD_REFUSE || slot_free);
  assign out_load  = (pop && cmd.kind == CMD_REFUSE) || (state == ST_OUT && slot_free);
  assign bit_len   = {length, 3'b000};

  assign win0  = blk[511:480];
  assign win1  = blk[479:448];
  assign win9  = blk[223:192];
  assign win14 = blk[63:32];
  assign w_new = win0 + (rotr(win1, 7) ^ rotr(win1, 18) ^ (win1 >> 3)) + win9 +
                 (rotr(win14, 17) ^ rotr(win14, 19) ^ (win14 >> 10));

  assign ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch +
              round_k(rnd) + win0;
  assign t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + mj;

  // Byte feed shared by absorb, padding and length insertion.
  always_comb begin
    do_push    = 1'b0;
    push_byte  = cmd.data;
    after_push = ST_IDLE;
    case (state)
      ST_IDLE: begin
        if (pop && (cmd.kind == CMD_ABSORB || cmd.kind == CMD_ABSORB_FIN)) begin
          do_push    = 1'b1;
          after_push = (cmd.kind == CMD_ABSORB_FIN) ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        after_push = ST_PAD;
        if (pad_first) begin
          do_push   = 1'b1;
          push_byte = PAD_BYTE;
        end else if (fill != LEN_FILL) begin
          do_push   = 1'b1;
          push_byte = 8'h00;
        end
      end
      ST_LEN: begin
        do_push    = 1'b1;
        push_byte  = bit_len[8*(7 - idx) +: 8];
        after_push = ST_OUT;
      end
      default: begin
        do_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      blk <= {blk[503:0], push_byte};
    end else if (state == ST_COMP) begin
      blk <= {blk[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_COMP) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= hash[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      fill      <= '0;
      length    <= '0;
      rnd       <= '0;
      idx       <= '0;
      pad_first <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= init_h(3'(i));
      end
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (do_push) begin
        fill <= fill + 7'd1;
        if (fill + 7'd1 == BLOCK_FILL) begin
          state     <= ST_COMP;
          ret_state <= after_push;
          rnd       <= '0;
        end else if (state == ST_IDLE) begin
          state <= after_push;
        end
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            pad_first <= 1'b1;
            idx       <= '0;
            case (cmd.kind)
              CMD_ABSORB, CMD_ABSORB_FIN: begin
                length <= length + 61'd1;
              end
              CMD_FINALIZE: begin
                state <= ST_PAD;
              end
              default: begin
                // Refuse: one result, state otherwise unchanged.
                out_valid  <= 1'b1;
                out_status <= 1'b1;
                out_index  <= '0;
                out_word   <= '0;
                out_last   <= 1'b1;
              end
            endcase
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (!pad_first && fill == LEN_FILL) begin
            state <= ST_LEN;
            idx   <= '0;
          end
        end
        ST_LEN: begin
          idx <= idx + 3'd1;
        end
        ST_COMP: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
          end
          fill  <= '0;
          idx   <= '0;
          state <= ret_state;
        end
        ST_OUT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_status <= 1'b0;
            out_index  <= idx;
            out_word   <= hash[idx];
            out_last   <= (idx == 3'd7);
            idx        <= idx + 3'd1;
            if (idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                hash[i] <= init_h(3'(i));
              end
              length <= '0;
              fill   <= '0;
              state  <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/sha256_message_hasher.sv
// SHA-256 message hasher top level: front end, command queue and back end.
// Absorbed bytes are shifted into the block; each full 64-byte block is compressed at one
//   round per cycle, then added into the hash words.
// Finalize: padding bytes, a turn to length insertion, the length bytes, then one or two
//   compressions, then eight digest words, one per cycle while m_tready is high.
// Reset (rst, synchronous): hash words to initial values, queue cleared.
`timescale 1ns / 1ps
module sha256_message_hasher import sha_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] word_index, [34:3] digest_word, [39:35] zero
  output logic [0:0]  m_tuser,   // [0] status
  output logic        m_tlast    // last_word
);

  logic        push;
  cmd_t        push_cmd;
  logic        pop;
  cmd_t        pop_cmd;
  logic        q_empty;
  logic        q_full;
  logic        status;
  logic [2:0]  word_index;
  logic [31:0] digest_word;

  // Classify each transaction and track the length limit.
  sha_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (s_tuser),
    .in_data    (s_tdata),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (q_full)
  );

  // Hold commands while the back end compresses.
  sha_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Assemble blocks, pad, compress and drive the registered output.
  sha_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (!q_empty),
    .cmd        (pop_cmd),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (status),
    .out_index  (word_index),
    .out_word   (digest_word),
    .out_last   (m_tlast)
  );

  assign m_tdata = {5'b00000, digest_word, word_index};
  assign m_tuser = status;

endmodule

// File: sim/sha256_message_hasher_tb.sv
// Testbench for sha256_message_hasher: byte-stream SHA-256 checked against a built-in predictor.
// Depends on sha_pkg (request codes, length limit) and the sha256_message_hasher RTL.
`timescale 1ns / 1ps
module sha256_message_hasher_tb;
  import sha_pkg::*;

  localparam int STALL_LIMIT  = 5000;  // cycles with no transaction before giving up
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int SETTLE       = 200;   // room for a two-block finalize
  localparam int RANDOM_ITEMS = 280;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic        status;
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last_word;
  } digest_beat_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic [1:0]  s_tuser;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [2:0] word_index, [34:3] digest_word, [39:35] zero
  logic [0:0]  m_tuser;   // [0] status
  logic        m_tlast;   // last_word

  sha256_message_hasher uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Predictor state: chaining words, pending block bytes, message length in bytes.
  logic [31:0] chain [8];
  logic [7:0]  pending [64];
  int          pend_cnt;
  logic [60:0] msg_len;

  digest_beat_t digest_q [$];
  int  err_cnt = 0;
  int  idle_cnt = 0;
  bit  sender_busy_free = 0;  // 1: sender offers back to back
  bit  recv_busy_free = 0;    // 1: receiver always ready
  bit  hold_rx = 0;           // request a long receiver hold-off

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic void sha_compress(input logic [7:0] blk [64]);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + K_TAB[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  function automatic void hasher_restart();
    for (int i = 0; i < 8; i++) chain[i] = H_INIT[i];
    for (int i = 0; i < 64; i++) pending[i] = 8'h00;
    pend_cnt = 0;
    msg_len = '0;
  endfunction

  // Work out the results caused by one accepted transaction and queue them.
  function automatic void predict_digest(input logic [1:0] req, input logic [7:0] b);
    logic [7:0]  blk [64];
    logic [63:0] bits;
    digest_beat_t beat;
    if (req == REQ_UNUSED) return;
    if (req != REQ_FINALIZE) begin
      // Length limit: refused whole, state untouched.
      if (msg_len == BYTE_LIMIT) begin
        beat = '{1'b1, 3'd0, 32'd0, 1'b1};
        digest_q.push_back(beat);
        return;
      end
      pending[pend_cnt] = b;
      pend_cnt++;
      msg_len++;
      if (pend_cnt == 64) begin
        sha_compress(pending);
        pend_cnt = 0;
      end
      if (req == REQ_ABSORB) return;
    end
    for (int i = 0; i < 64; i++) blk[i] = (i < pend_cnt) ? pending[i] : 8'h00;
    blk[pend_cnt] = PAD_BYTE;
    // Too little room for the length field: spill into a second block.
    if (pend_cnt + 1 > 56) begin
      sha_compress(blk);
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    end
    bits = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
    sha_compress(blk);
    for (int i = 0; i < 8; i++) begin
      beat = '{1'b0, 3'(i), chain[i], (i == 7)};
      digest_q.push_back(beat);
    end
    hasher_restart();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR t=%0t %s: got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Offer one transaction; hold valid across back-to-back items without toggling it.
  task automatic send_item(input logic [1:0] req, input logic [7:0] b);
    int gap;
    gap = sender_busy_free ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_digest(req, b);
  endtask

  task automatic sender_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Pause the sender until every queued digest word has come back.
  task automatic wait_for_drain();
    sender_idle();
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Send a message of n random bytes; close it with absorb-and-finalize or a bare finalize.
  task automatic send_message(input int n, input int noise_pct);
    bit fin_on_byte;
    fin_on_byte = (n > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(REQ_UNUSED, 8'($urandom));
      if (fin_on_byte && i == n - 1) send_item(REQ_ABSORB_FIN, 8'($urandom));
      else send_item(REQ_ABSORB, 8'($urandom));
    end
    if (!fin_on_byte) send_item(REQ_FINALIZE, 8'($urandom));
  endtask

  task automatic test_empty_message();
    send_item(REQ_FINALIZE, 8'h00);
    send_item(REQ_FINALIZE, 8'hff);  // data byte ignored on a bare finalize
  endtask

  task automatic test_byte_extremes();
    send_item(REQ_ABSORB_FIN, 8'h00);
    send_item(REQ_ABSORB_FIN, 8'hff);
    send_item(REQ_ABSORB, 8'h61);
    send_item(REQ_ABSORB, 8'h62);
    send_item(REQ_ABSORB_FIN, 8'h63);
  endtask

  task automatic test_unused_code();
    // An unused request code must leave the message untouched.
    send_item(REQ_ABSORB, 8'h5a);
    send_item(REQ_UNUSED, 8'hff);
    send_item(REQ_UNUSED, 8'h00);
    send_item(REQ_ABSORB, 8'ha5);
    send_item(REQ_FINALIZE, 8'h00);
  endtask

  // The length limit sits at 2^61-1 bytes and cannot be reached in simulation; the
  // predictor still models the refusal so any stray refusal is flagged.

  task automatic test_output_backpressure();
    wait_for_drain();
    hold_rx = 1'b1;
    sender_busy_free = 1'b1;
    // Later messages carry more items than the queue holds, so the input stalls.
    for (int m = 0; m < 3; m++) send_message($urandom_range(4, 8), 0);
    sender_busy_free = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_random_messages();
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // Padding edges get extra weight; most messages stay short.
      case ($urandom_range(0, 7))
        0: n = 55;
        1: n = 56;
        2: n = 63 + $urandom_range(0, 1);
        default: n = $urandom_range(0, 20);
      endcase
      sender_busy_free = ($urandom_range(0, 3) == 0);
      recv_busy_free   = ($urandom_range(0, 3) == 0);
      send_message(n, 8);
      sent += n + 1;
    end
    sender_busy_free = 1'b0;
    recv_busy_free   = 1'b0;
  endtask

  // Receiver: random ready gaps, plus one long hold-off on request.
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      gap = recv_busy_free ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[34:3], 32'd0);
      end else begin
        want = digest_q.pop_front();
        if (m_tuser[0] !== want.status)
          report_mismatch("status", 32'(m_tuser[0]), 32'(want.status));
        if (m_tdata[2:0] !== want.word_index)
          report_mismatch("word_index", 32'(m_tdata[2:0]), 32'(want.word_index));
        if (m_tdata[34:3] !== want.digest_word)
          report_mismatch("digest_word", m_tdata[34:3], want.digest_word);
        if (m_tlast !== want.last_word)
          report_mismatch("last_word", 32'(m_tlast), 32'(want.last_word));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = REQ_ABSORB;
    hasher_restart();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_message();
    test_byte_extremes();
    test_unused_code();
    test_output_backpressure();
    test_random_messages();

    wait_for_drain();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
